@@ hw/rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int B64D_QUEUE_DEPTH = 2;
    localparam logic [15:0] B64D_LEN_MAX = 16'hFFFF;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] CHAR_D0    = 8'h30;
    localparam logic [7:0] CHAR_D9    = 8'h39;

    localparam logic [5:0] SEXT_LC_BASE = 6'd26;
    localparam logic [5:0] SEXT_DG_BASE = 6'd52;
    localparam logic [5:0] SEXT_PLUS    = 6'd62;
    localparam logic [5:0] SEXT_SLASH   = 6'd63;

    typedef struct packed {
        logic       valid;
        logic       pad;
        logic [5:0] sextet;
    } b64d_class_t;

    // Compacted output bytes of one item: cnt bytes from bytes[0] up,
    // cnt of zero with eot set is a bare end mark.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            eot;
    } b64d_job_t;

    function automatic b64d_class_t classify(input logic [7:0] c);
        b64d_class_t r;
        logic [7:0]  d;
        r = '0;
        d = '0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z)
        begin
            d        = c - CHAR_UC_A;
            r.valid  = 1'b1;
            r.sextet = d[5:0];
        end
        else if (c >= CHAR_LC_A && c <= CHAR_LC_Z)
        begin
            d        = c - CHAR_LC_A;
            r.valid  = 1'b1;
            r.sextet = d[5:0] + SEXT_LC_BASE;
        end
        else if (c >= CHAR_D0 && c <= CHAR_D9)
        begin
            d        = c - CHAR_D0;
            r.valid  = 1'b1;
            r.sextet = d[5:0] + SEXT_DG_BASE;
        end
        else if (c == CHAR_PLUS)
        begin
            r.valid  = 1'b1;
            r.sextet = SEXT_PLUS;
        end
        else if (c == CHAR_SLASH || c == CHAR_PAD)
        begin
            r.valid  = 1'b1;
            r.pad    = (c == CHAR_PAD);
            r.sextet = SEXT_SLASH;
        end
        return r;
    endfunction

    function automatic b64d_job_t group_bytes(input logic [5:0] s1, input logic [5:0] s2,
                                              input logic [5:0] s3, input logic [5:0] s4,
                                              input logic skip2, input logic skip3);
        b64d_job_t  j;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        b0 = {s1, s2[5:4]};
        b1 = {s2[3:0], s3[5:2]};
        b2 = {s3[1:0], s4};
        j  = '0;
        j.bytes[0] = b0;
        if (!skip2)
        begin
            j.bytes[1] = b1;
            j.bytes[2] = b2;
            j.cnt      = skip3 ? 2'd2 : 2'd3;
        end
        else
        begin
            j.bytes[1] = b2;
            j.cnt      = skip3 ? 2'd1 : 2'd2;
        end
        return j;
    endfunction

endpackage

@@ hw/rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front
// Classifies characters, holds the partial group and builds byte jobs.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [7:0] char_in,
    input  logic      end_of_text,
    output logic      job_valid,
    output b64d_job_t job
);

    logic [17:0] held_reg;
    logic [17:0] held_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        twp_reg;
    logic        twp_next;

    b64d_class_t cls;
    logic        complete;
    logic [17:0] held_mid;
    logic [1:0]  count_mid;
    logic        twp_mid;
    logic [17:0] h;

    always_comb
    begin
        cls       = classify(char_in);
        complete  = cls.valid && (count_reg == 2'd3);
        held_mid  = held_reg;
        count_mid = count_reg;
        twp_mid   = twp_reg;
        if (complete)
        begin
            held_mid  = '0;
            count_mid = '0;
            twp_mid   = 1'b0;
        end
        else if (cls.valid)
        begin
            held_mid  = {held_reg[11:0], cls.sextet};
            count_mid = count_reg + 2'd1;
            if (count_reg == 2'd2)
            begin
                twp_mid = cls.pad;
            end
        end

        case (count_mid)
            2'd1:    h = {held_mid[5:0], 12'd0};
            2'd2:    h = {held_mid[11:0], 6'd0};
            default: h = held_mid;
        endcase

        job_valid = accept && (complete || end_of_text);
        if (complete)
        begin
            job = group_bytes(held_reg[17:12], held_reg[11:6], held_reg[5:0],
                              cls.sextet, twp_reg, cls.pad);
        end
        else if (count_mid != 2'd0)
        begin
            job = group_bytes(h[17:12], h[11:6], h[5:0], 6'd0,
                              (count_mid == 2'd3) && twp_mid, 1'b0);
        end
        else
        begin
            job = '0;
        end
        job.eot = end_of_text;

        held_next  = held_reg;
        count_next = count_reg;
        twp_next   = twp_reg;
        if (accept)
        begin
            if (end_of_text)
            begin
                held_next  = '0;
                count_next = '0;
                twp_next   = 1'b0;
            end
            else
            begin
                held_next  = held_mid;
                count_next = count_mid;
                twp_next   = twp_mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= '0;
            count_reg <= '0;
            twp_reg   <= 1'b0;
        end
        else
        begin
            held_reg  <= held_next;
            count_reg <= count_next;
            twp_reg   <= twp_next;
        end
    end

endmodule

@@ hw/rtl/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = B64D_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64d_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output b64d_job_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    b64d_job_t     mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full      = (count_reg == DEPTH_C);
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back
// Serializes job bytes into result items and keeps the decoded length.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_ready,
    input  b64d_job_t   job,
    output logic        job_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        has_data,
    output logic        last,
    output logic [15:0] decoded_length
);

    logic [1:0]  sel_reg;
    logic [1:0]  sel_next;
    logic [15:0] total_reg;
    logic [15:0] total_next;
    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic        has_reg;
    logic        last_reg;
    logic [15:0] len_reg;

    logic        load;
    logic        final_byte;
    logic [15:0] total_inc;

    assign out_valid      = valid_reg;
    assign data_byte      = byte_reg;
    assign has_data       = has_reg;
    assign last           = last_reg;
    assign decoded_length = len_reg;

    always_comb
    begin
        load       = job_ready && (!valid_reg || out_ready);
        final_byte = (sel_reg == job.cnt - 2'd1);
        total_inc  = (total_reg == B64D_LEN_MAX) ? total_reg : total_reg + 16'd1;
        job_pop    = load && ((job.cnt == 2'd0) || final_byte);
        sel_next   = sel_reg;
        total_next = total_reg;
        if (load)
        begin
            if (job.cnt == 2'd0)
            begin
                total_next = '0;
            end
            else if (final_byte)
            begin
                sel_next   = '0;
                total_next = job.eot ? 16'd0 : total_inc;
            end
            else
            begin
                sel_next   = sel_reg + 2'd1;
                total_next = total_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            total_reg <= total_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (job.cnt == 2'd0)
            begin
                byte_reg <= '0;
                has_reg  <= 1'b0;
                last_reg <= 1'b1;
                len_reg  <= total_reg;
            end
            else
            begin
                byte_reg <= job.bytes[sel_reg];
                has_reg  <= 1'b1;
                last_reg <= job.eot && final_byte;
                len_reg  <= total_inc;
            end
        end
    end

endmodule

@@ hw/rtl/base64_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one character per item in, one byte per item out.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tdata[7:0] is a character, s_tlast marks end of text.
// Characters outside the base64 alphabet are dropped; '=' counts as a sextet.
// Output channel m_*: m_tdata[7:0] decoded byte, m_tdata[23:8] running
// decoded length (saturates at 65535), m_tuser set when a byte is carried,
// m_tlast on the final item of a text. A text with nothing pending at its
// end gives one item with m_tuser low and m_tlast high.
// Throughput: one character per cycle while s_tready is high; the back end
// gives one item per cycle while m_tready is high, so a burst of end-of-text
// groups can hold s_tready low while the job queue is full.
// A byte goes from the front into the queue, then from the queue head into
// the output register, before it shows on m_*.
// Reset clears the held group, the queue and the output valid flag.
// When m_tready is low the output item holds, the queue fills, then s_tready
// drops; nothing is lost.
// ----------------------------------------------------------------------------
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = B64D_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_in
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] decoded_length
    output logic        m_tuser,   // [0] has_data
    output logic        m_tlast    // last
);

    logic      full;
    logic      accept;
    logic      job_valid;
    b64d_job_t job;
    logic      q_pop;
    logic      q_not_empty;
    b64d_job_t q_head;
    logic [7:0]  data_byte;
    logic [15:0] decoded_length;

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = {decoded_length, data_byte};

    b64d_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_in     (s_tdata),
        .end_of_text (s_tlast),
        .job_valid   (job_valid),
        .job         (job)
    );

    b64d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_job  (job),
        .full      (full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    b64d_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_ready      (q_not_empty),
        .job            (q_head),
        .job_pop        (q_pop),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .data_byte      (data_byte),
        .has_data       (m_tuser),
        .last           (m_tlast),
        .decoded_length (decoded_length)
    );

endmodule

@@ hw/rtl/b64d_checker.sv @@
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("bare end mark without tlast");

    a_bare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("bare end mark with nonzero byte");

    a_len_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[23:8] != 16'd0)
        else $error("data item with zero length");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
